// ===== design/gfqt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gfqt_pkg
// Shared types and constants of the fence queue tracker.
// ----------------------------------------------------------------------------
package gfqt_pkg;

	localparam int OP_W        = 3;
	localparam int KEY_W       = 32;
	localparam int QI_W        = 2;
	localparam int FI_W        = 4;
	localparam int VAL_W       = 64;
	localparam int H_W         = 32;
	localparam int KIND_W      = 2;
	localparam int MAX_RESULTS = 32;
	localparam int RCNT_W      = 6;
	localparam int STACK_DEPTH = 32;
	localparam int STK_AW      = 5;
	localparam int SDEP_W      = 6;

	// input operations
	localparam logic [OP_W-1:0] OP_WAIT   = 3'd0;
	localparam logic [OP_W-1:0] OP_SIGNAL = 3'd1;
	localparam logic [OP_W-1:0] OP_EXEC   = 3'd2;
	localparam logic [OP_W-1:0] OP_HOST   = 3'd3;
	localparam logic [OP_W-1:0] OP_QUERY  = 3'd4;

	// queued event kinds
	localparam logic [1:0] EV_WAIT   = 2'd0;
	localparam logic [1:0] EV_SIGNAL = 2'd1;
	localparam logic [1:0] EV_EXEC   = 2'd2;

	// result kinds
	localparam logic [KIND_W-1:0] RK_RELEASE  = 2'd0;
	localparam logic [KIND_W-1:0] RK_QUERY    = 2'd1;
	localparam logic [KIND_W-1:0] RK_OVERFLOW = 2'd2;

	typedef struct packed {
		logic [1:0]       kind;
		logic [KEY_W-1:0] key;
		logic [FI_W-1:0]  fence;
		logic [VAL_W-1:0] value;
		logic [H_W-1:0]   handle;
	} ev_t;

	typedef struct packed {
		logic [FI_W-1:0]  fence;
		logic [VAL_W-1:0] value;
	} sig_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [KEY_W-1:0]  key;
		logic [QI_W-1:0]   queue;
		logic [H_W-1:0]    handle;
		logic              waiting;
	} res_t;

	typedef enum logic [1:0] {
		EM_QUERY,
		EM_REL_IN,
		EM_OVF,
		EM_REL_EV
	} emit_sel_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISP,
		ST_WCHK,
		ST_FIRE,
		ST_SCAN,
		ST_EVCHK,
		ST_FCHK,
		ST_PUSHRD,
		ST_PUSHWR,
		ST_POP,
		ST_POPRD,
		ST_POPLD,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic      latch_in;
		logic      emit;
		emit_sel_t emit_sel;
		logic      enq;
		logic      fire_arg_in;
		logic      fire_wr;
		logic      scan_next;
		logic      pop;
		logic      take;
		logic      fence_ev;
		logic      push_init;
		logic      push_wr;
		logic      pop_stack;
		logic      load_stack;
		logic      flush;
	} cmd_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            qok;
		logic            fok;
		logic            q_empty;
		logic            q_full;
		logic            in_sat;
		logic            scan_end;
		logic            cur_empty;
		logic [1:0]      ev_kind;
		logic            ev_sat;
		logic            nt_zero;
		logic            i_one;
		logic            depth_zero;
		logic            emit_ready;
		logic            flush_ready;
	} stat_t;

endpackage
`default_nettype wire

// ===== design/gfqt_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gfqt_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module gfqt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                  clk,
	input  wire logic                                  we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                      wdata,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ===== design/gfqt_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gfqt_ctrl
// Sequencer: dispatch, queue drain, signal replay and result flush.
// ----------------------------------------------------------------------------
module gfqt_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire gfqt_pkg::stat_t st,
	output gfqt_pkg::cmd_t      cmd
);

	gfqt_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gfqt_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			gfqt_pkg::ST_IDLE: begin
				if (in_valid) state_d = gfqt_pkg::ST_DISP;
			end
			gfqt_pkg::ST_DISP: begin
				case (st.op)
					gfqt_pkg::OP_WAIT: begin
						state_d = (st.qok && st.fok) ? gfqt_pkg::ST_WCHK : gfqt_pkg::ST_DONE;
					end
					gfqt_pkg::OP_SIGNAL: begin
						if (!(st.qok && st.fok)) state_d = gfqt_pkg::ST_DONE;
						else if (st.q_empty) state_d = gfqt_pkg::ST_FIRE;
						else if (!st.q_full || st.emit_ready) state_d = gfqt_pkg::ST_DONE;
					end
					gfqt_pkg::OP_EXEC: begin
						if (!st.qok) state_d = gfqt_pkg::ST_DONE;
						else if ((st.q_empty || st.q_full) && !st.emit_ready)
							state_d = gfqt_pkg::ST_DISP;
						else state_d = gfqt_pkg::ST_DONE;
					end
					gfqt_pkg::OP_HOST: begin
						state_d = st.fok ? gfqt_pkg::ST_FIRE : gfqt_pkg::ST_DONE;
					end
					gfqt_pkg::OP_QUERY: begin
						if (st.emit_ready) state_d = gfqt_pkg::ST_DONE;
					end
					default: state_d = gfqt_pkg::ST_DONE;
				endcase
			end
			gfqt_pkg::ST_WCHK: begin
				if (st.in_sat || !st.q_full || st.emit_ready) state_d = gfqt_pkg::ST_DONE;
			end
			gfqt_pkg::ST_FIRE: state_d = gfqt_pkg::ST_SCAN;
			gfqt_pkg::ST_SCAN: begin
				if (st.scan_end) begin
					state_d = st.nt_zero ? gfqt_pkg::ST_POP : gfqt_pkg::ST_PUSHRD;
				end else if (!st.cur_empty) begin
					state_d = gfqt_pkg::ST_EVCHK;
				end
			end
			gfqt_pkg::ST_EVCHK: begin
				if (st.ev_kind == gfqt_pkg::EV_WAIT) state_d = gfqt_pkg::ST_FCHK;
				else if (st.ev_kind != gfqt_pkg::EV_EXEC || st.emit_ready)
					state_d = gfqt_pkg::ST_SCAN;
			end
			gfqt_pkg::ST_FCHK:   state_d = gfqt_pkg::ST_SCAN;
			gfqt_pkg::ST_PUSHRD: state_d = gfqt_pkg::ST_PUSHWR;
			gfqt_pkg::ST_PUSHWR: state_d = st.i_one ? gfqt_pkg::ST_POP : gfqt_pkg::ST_PUSHRD;
			gfqt_pkg::ST_POP:    state_d = st.depth_zero ? gfqt_pkg::ST_DONE : gfqt_pkg::ST_POPRD;
			gfqt_pkg::ST_POPRD:  state_d = gfqt_pkg::ST_POPLD;
			gfqt_pkg::ST_POPLD:  state_d = gfqt_pkg::ST_FIRE;
			gfqt_pkg::ST_DONE: begin
				if (st.flush_ready) state_d = gfqt_pkg::ST_IDLE;
			end
			default: state_d = gfqt_pkg::ST_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd = '0;
		cmd.emit_sel = gfqt_pkg::EM_QUERY;
		in_ready = 1'b0;
		case (state_q)
			gfqt_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.latch_in = in_valid;
			end
			gfqt_pkg::ST_DISP: begin
				case (st.op)
					gfqt_pkg::OP_SIGNAL: begin
						if (st.qok && st.fok) begin
							if (st.q_empty) begin
								cmd.fire_arg_in = 1'b1;
							end else if (st.q_full) begin
								cmd.emit     = st.emit_ready;
								cmd.emit_sel = gfqt_pkg::EM_OVF;
							end else begin
								cmd.enq = 1'b1;
							end
						end
					end
					gfqt_pkg::OP_EXEC: begin
						if (st.qok) begin
							if (st.q_empty) begin
								cmd.emit     = st.emit_ready;
								cmd.emit_sel = gfqt_pkg::EM_REL_IN;
							end else if (st.q_full) begin
								cmd.emit     = st.emit_ready;
								cmd.emit_sel = gfqt_pkg::EM_OVF;
							end else begin
								cmd.enq = 1'b1;
							end
						end
					end
					gfqt_pkg::OP_HOST: cmd.fire_arg_in = st.fok;
					gfqt_pkg::OP_QUERY: begin
						cmd.emit     = st.emit_ready;
						cmd.emit_sel = gfqt_pkg::EM_QUERY;
					end
					default: ;
				endcase
			end
			gfqt_pkg::ST_WCHK: begin
				if (!st.in_sat) begin
					if (st.q_full) begin
						cmd.emit     = st.emit_ready;
						cmd.emit_sel = gfqt_pkg::EM_OVF;
					end else begin
						cmd.enq = 1'b1;
					end
				end
			end
			gfqt_pkg::ST_FIRE: cmd.fire_wr = 1'b1;
			gfqt_pkg::ST_SCAN: begin
				cmd.scan_next = !st.scan_end && st.cur_empty;
				cmd.push_init = st.scan_end && !st.nt_zero;
			end
			gfqt_pkg::ST_EVCHK: begin
				cmd.fence_ev = 1'b1;
				if (st.ev_kind == gfqt_pkg::EV_EXEC) begin
					cmd.emit     = st.emit_ready;
					cmd.emit_sel = gfqt_pkg::EM_REL_EV;
					cmd.pop      = st.emit_ready;
				end else if (st.ev_kind != gfqt_pkg::EV_WAIT) begin
					cmd.take = 1'b1;
					cmd.pop  = 1'b1;
				end
			end
			gfqt_pkg::ST_FCHK: begin
				cmd.fence_ev  = 1'b1;
				cmd.pop       = st.ev_sat;
				cmd.scan_next = !st.ev_sat;
			end
			gfqt_pkg::ST_PUSHWR: cmd.push_wr = 1'b1;
			gfqt_pkg::ST_POP:    cmd.pop_stack = !st.depth_zero;
			gfqt_pkg::ST_POPLD:  cmd.load_stack = 1'b1;
			gfqt_pkg::ST_DONE:   cmd.flush = st.flush_ready;
			default: ;
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> st.emit_ready)
		else $error("emit issued while result path is blocked");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == gfqt_pkg::ST_POPLD) |=> (state_q == gfqt_pkg::ST_FIRE))
		else $error("replay did not restart drain");
	assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !(cmd.enq || cmd.pop || cmd.emit))
		else $error("state change while idle");

endmodule
`default_nettype wire

// ===== design/gfqt_dpath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gfqt_dpath
// Queue storage, fence values, replay stack and result registers.
// ----------------------------------------------------------------------------
module gfqt_dpath #(
	parameter int NUM_QUEUES  = 4,
	parameter int QUEUE_DEPTH = 8,
	parameter int NUM_FENCES  = 16
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic [gfqt_pkg::OP_W-1:0]      op,
	input  wire logic [gfqt_pkg::KEY_W-1:0]     call_key,
	input  wire logic [gfqt_pkg::QI_W-1:0]      queue_index,
	input  wire logic [gfqt_pkg::FI_W-1:0]      fence_index,
	input  wire logic [gfqt_pkg::VAL_W-1:0]     fence_value,
	input  wire logic [gfqt_pkg::H_W-1:0]       exec_handle,
	input  wire gfqt_pkg::cmd_t                 cmd,
	output gfqt_pkg::stat_t                     st,
	input  wire logic                           out_stall,
	output logic                                out_valid,
	output gfqt_pkg::res_t                      res,
	output logic                                res_last
);

	localparam int SLOTS = NUM_QUEUES * QUEUE_DEPTH;
	localparam int QW    = NUM_QUEUES > 1 ? $clog2(NUM_QUEUES) : 1;
	localparam int SCW   = $clog2(NUM_QUEUES + 1);
	localparam int HW    = $clog2(QUEUE_DEPTH);
	localparam int CW    = $clog2(QUEUE_DEPTH + 1);
	localparam int PW    = CW + 1;
	localparam int SW    = $clog2(SLOTS);
	localparam int NTW   = $clog2(SLOTS + 1);
	localparam int FW    = NUM_FENCES > 1 ? $clog2(NUM_FENCES) : 1;
	localparam int EVW   = $bits(gfqt_pkg::ev_t);
	localparam int SGW   = $bits(gfqt_pkg::sig_t);

	logic [gfqt_pkg::OP_W-1:0]  op_q;
	logic [gfqt_pkg::KEY_W-1:0] key_q;
	logic [gfqt_pkg::QI_W-1:0]  qi_q;
	logic [gfqt_pkg::FI_W-1:0]  fi_q;
	logic [gfqt_pkg::VAL_W-1:0] val_q;
	logic [gfqt_pkg::H_W-1:0]   h_q;

	logic [gfqt_pkg::FI_W-1:0]  cur_f_q;
	logic [gfqt_pkg::VAL_W-1:0] cur_v_q;

	logic [HW-1:0]  head_q [NUM_QUEUES];
	logic [CW-1:0]  cnt_q  [NUM_QUEUES];
	logic [NUM_FENCES-1:0] seen_q;
	logic [SCW-1:0] scan_q;
	logic [NTW-1:0] nt_q, i_q;
	logic [gfqt_pkg::SDEP_W-1:0] depth_q;
	logic [gfqt_pkg::RCNT_W-1:0] rcnt_q;

	gfqt_pkg::res_t hold_q;
	logic           hold_v_q;

	logic [QW-1:0] in_qsel, sc_qsel;
	logic          qok, fok;
	logic [PW-1:0] psum, wpos;
	logic [SW-1:0] wslot, rslot;

	gfqt_pkg::ev_t  ev_wr, ev_rd;
	gfqt_pkg::sig_t tmp_rd, stk_rd;
	logic [gfqt_pkg::VAL_W-1:0] frd;
	logic [FW-1:0] f_raddr;
	logic          res_full, out_free, hold_to_out;
	gfqt_pkg::res_t new_res;

	assign qok     = 32'(qi_q) < NUM_QUEUES;
	assign fok     = 32'(fi_q) < NUM_FENCES;
	assign in_qsel = QW'(qi_q);
	assign sc_qsel = scan_q[QW-1:0];

	// tail position of the addressed queue, modulo the depth
	assign psum  = PW'(head_q[in_qsel]) + PW'(cnt_q[in_qsel]);
	assign wpos  = (psum >= PW'(QUEUE_DEPTH)) ? psum - PW'(QUEUE_DEPTH) : psum;
	assign wslot = SW'(int'(in_qsel) * QUEUE_DEPTH + int'(wpos));
	assign rslot = SW'(int'(sc_qsel) * QUEUE_DEPTH + int'(head_q[sc_qsel]));

	always_comb begin
		ev_wr.key    = key_q;
		ev_wr.fence  = fi_q;
		ev_wr.value  = val_q;
		ev_wr.handle = h_q;
		case (op_q)
			gfqt_pkg::OP_WAIT:   ev_wr.kind = gfqt_pkg::EV_WAIT;
			gfqt_pkg::OP_SIGNAL: ev_wr.kind = gfqt_pkg::EV_SIGNAL;
			default:             ev_wr.kind = gfqt_pkg::EV_EXEC;
		endcase
	end

	gfqt_ram #(.WIDTH(EVW), .DEPTH(SLOTS)) u_ev_ram (
		.clk   (clk),
		.we    (cmd.enq),
		.waddr (wslot),
		.wdata (ev_wr),
		.raddr (rslot),
		.rdata (ev_rd)
	);

	assign f_raddr = cmd.fence_ev ? FW'(ev_rd.fence) : FW'(fi_q);

	gfqt_ram #(.WIDTH(gfqt_pkg::VAL_W), .DEPTH(NUM_FENCES)) u_fence_ram (
		.clk   (clk),
		.we    (cmd.fire_wr && 32'(cur_f_q) < NUM_FENCES),
		.waddr (FW'(cur_f_q)),
		.wdata (cur_v_q),
		.raddr (f_raddr),
		.rdata (frd)
	);

	gfqt_ram #(.WIDTH(SGW), .DEPTH(SLOTS)) u_take_ram (
		.clk   (clk),
		.we    (cmd.take && 32'(nt_q) < SLOTS),
		.waddr (SW'(nt_q)),
		.wdata ({ev_rd.fence, ev_rd.value}),
		.raddr (SW'(i_q - NTW'(1))),
		.rdata (tmp_rd)
	);

	gfqt_ram #(.WIDTH(SGW), .DEPTH(gfqt_pkg::STACK_DEPTH)) u_stack_ram (
		.clk   (clk),
		.we    (cmd.push_wr && depth_q < gfqt_pkg::SDEP_W'(gfqt_pkg::STACK_DEPTH)),
		.waddr (depth_q[gfqt_pkg::STK_AW-1:0]),
		.wdata (tmp_rd),
		.raddr (depth_q[gfqt_pkg::STK_AW-1:0]),
		.rdata (stk_rd)
	);

	// input word and fire arguments
	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			op_q  <= op;
			key_q <= call_key;
			qi_q  <= queue_index;
			fi_q  <= fence_index;
			val_q <= fence_value;
			h_q   <= exec_handle;
		end
		if (cmd.fire_arg_in) begin
			cur_f_q <= fi_q;
			cur_v_q <= val_q;
		end else if (cmd.load_stack) begin
			cur_f_q <= stk_rd.fence;
			cur_v_q <= stk_rd.value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int q = 0; q < NUM_QUEUES; q++) begin
				head_q[q] <= '0;
				cnt_q[q]  <= '0;
			end
			seen_q  <= '0;
			scan_q  <= '0;
			nt_q    <= '0;
			i_q     <= '0;
			depth_q <= '0;
		end else begin
			if (cmd.enq) begin
				cnt_q[in_qsel] <= cnt_q[in_qsel] + CW'(1);
			end
			if (cmd.pop) begin
				head_q[sc_qsel] <= (head_q[sc_qsel] == HW'(QUEUE_DEPTH - 1)) ? '0
					: head_q[sc_qsel] + HW'(1);
				cnt_q[sc_qsel]  <= cnt_q[sc_qsel] - CW'(1);
			end
			if (cmd.fire_wr) begin
				if (32'(cur_f_q) < NUM_FENCES) seen_q[FW'(cur_f_q)] <= 1'b1;
				scan_q <= '0;
				nt_q   <= '0;
			end
			if (cmd.scan_next) scan_q <= scan_q + SCW'(1);
			if (cmd.take && 32'(nt_q) < SLOTS) nt_q <= nt_q + NTW'(1);
			if (cmd.push_init) i_q <= nt_q;
			if (cmd.push_wr) begin
				i_q <= i_q - NTW'(1);
				if (depth_q < gfqt_pkg::SDEP_W'(gfqt_pkg::STACK_DEPTH))
					depth_q <= depth_q + gfqt_pkg::SDEP_W'(1);
			end
			if (cmd.pop_stack) depth_q <= depth_q - gfqt_pkg::SDEP_W'(1);
		end
	end

	// result word
	always_comb begin
		new_res = '0;
		new_res.key   = key_q;
		new_res.queue = qi_q;
		case (cmd.emit_sel)
			gfqt_pkg::EM_QUERY: begin
				new_res.kind    = gfqt_pkg::RK_QUERY;
				new_res.waiting = qok && (cnt_q[in_qsel] != '0);
			end
			gfqt_pkg::EM_REL_IN: begin
				new_res.kind   = gfqt_pkg::RK_RELEASE;
				new_res.handle = h_q;
			end
			gfqt_pkg::EM_OVF: begin
				new_res.kind   = gfqt_pkg::RK_OVERFLOW;
				new_res.handle = (op_q == gfqt_pkg::OP_EXEC) ? h_q : '0;
			end
			gfqt_pkg::EM_REL_EV: begin
				new_res.kind   = gfqt_pkg::RK_RELEASE;
				new_res.key    = ev_rd.key;
				new_res.queue  = gfqt_pkg::QI_W'(scan_q);
				new_res.handle = ev_rd.handle;
			end
			default: ;
		endcase
	end

	assign res_full    = rcnt_q >= gfqt_pkg::RCNT_W'(gfqt_pkg::MAX_RESULTS);
	assign out_free    = !out_valid || !out_stall;
	assign hold_to_out = hold_v_q && ((cmd.emit && !res_full) || cmd.flush);

	// one word is held back so that the final word of an item can be marked
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			hold_v_q  <= 1'b0;
			rcnt_q    <= '0;
		end else begin
			if (hold_to_out) out_valid <= 1'b1;
			else if (out_free) out_valid <= 1'b0;
			if (cmd.emit && !res_full) begin
				rcnt_q   <= rcnt_q + gfqt_pkg::RCNT_W'(1);
				hold_v_q <= 1'b1;
			end
			if (cmd.flush) begin
				rcnt_q   <= '0;
				hold_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit && !res_full) begin
			hold_q <= new_res;
			if (hold_v_q) begin
				res      <= hold_q;
				res_last <= 1'b0;
			end
		end
		if (cmd.flush && hold_v_q) begin
			res      <= hold_q;
			res_last <= 1'b1;
		end
	end

	always_comb begin
		st.op          = op_q;
		st.qok         = qok;
		st.fok         = fok;
		st.q_empty     = cnt_q[in_qsel] == '0;
		st.q_full      = cnt_q[in_qsel] == CW'(QUEUE_DEPTH);
		st.in_sat      = seen_q[FW'(fi_q)] && (frd >= val_q);
		st.scan_end    = scan_q == SCW'(NUM_QUEUES);
		st.cur_empty   = cnt_q[sc_qsel] == '0;
		st.ev_kind     = ev_rd.kind;
		st.ev_sat      = seen_q[FW'(ev_rd.fence)] && (frd >= ev_rd.value);
		st.nt_zero     = nt_q == '0;
		st.i_one       = i_q == NTW'(1);
		st.depth_zero  = depth_q == '0;
		st.emit_ready  = res_full || !hold_v_q || out_free;
		st.flush_ready = !hold_v_q || out_free;
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= gfqt_pkg::SDEP_W'(gfqt_pkg::STACK_DEPTH))
		else $error("replay stack depth out of range");
	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q[0] <= CW'(QUEUE_DEPTH))
		else $error("queue count exceeds depth");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.flush |=> !hold_v_q && rcnt_q == '0)
		else $error("held word survived flush");

endmodule
`default_nettype wire

// ===== design/gpu_fence_queue_tracker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gpu_fence_queue_tracker
// Tracks command queues blocked on fences and releases work as fences signal.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_stall carry one op word (wait, signal, execute,
// host fence signal, query). in_stall is high while an item is in progress;
// one item is handled at a time.
// Output channel: out_valid/out_stall carry result words; last marks the final
// word of an item. One word is held back internally until the next word or the
// end of the item is known, so last is exact.
// Sequence: a query, execute or queued signal passes dispatch and done; a wait
// also passes a check of its fence. A fence signal fires the fence; a drain
// pass then scans each queue, skipping empty ones, checks each head event and
// checks the fence of a wait; then the taken signals are pushed, and each
// replayed signal is popped, read and loaded before a new drain pass, until a
// final stack check finds the stack empty. The drain walks the event RAM.
// A stalled receiver holds the output register; the sequencer then waits at the
// next result it has to emit.
// Reset clears queue counters, fence seen bits and the replay stack; RAM
// contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module gpu_fence_queue_tracker #(
	parameter int NUM_QUEUES  = 4,
	parameter int QUEUE_DEPTH = 8,
	parameter int NUM_FENCES  = 16
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic [gfqt_pkg::OP_W-1:0]      op,
	input  wire logic [gfqt_pkg::KEY_W-1:0]     call_key,
	input  wire logic [gfqt_pkg::QI_W-1:0]      queue_index,
	input  wire logic [gfqt_pkg::FI_W-1:0]      fence_index,
	input  wire logic [gfqt_pkg::VAL_W-1:0]     fence_value,
	input  wire logic [gfqt_pkg::H_W-1:0]       exec_handle,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic [gfqt_pkg::KIND_W-1:0]         kind,
	output logic [gfqt_pkg::KEY_W-1:0]          call_key_res,
	output logic [gfqt_pkg::QI_W-1:0]           queue_index_res,
	output logic [gfqt_pkg::H_W-1:0]            exec_handle_res,
	output logic                                waiting,
	output logic                                last
);

	gfqt_pkg::cmd_t  cmd;
	gfqt_pkg::stat_t st;
	gfqt_pkg::res_t  res;
	logic            in_ready;

	assign in_stall = !in_ready;

	gfqt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	gfqt_dpath #(
		.NUM_QUEUES  (NUM_QUEUES),
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.NUM_FENCES  (NUM_FENCES)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.op          (op),
		.call_key    (call_key),
		.queue_index (queue_index),
		.fence_index (fence_index),
		.fence_value (fence_value),
		.exec_handle (exec_handle),
		.cmd         (cmd),
		.st          (st),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.res         (res),
		.res_last    (last)
	);

	assign kind            = res.kind;
	assign call_key_res    = res.key;
	assign queue_index_res = res.queue;
	assign exec_handle_res = res.handle;
	assign waiting         = res.waiting;

endmodule
`default_nettype wire
